FILE: rtl/xpd_pkg.sv
// Shared types and constants for the pack-file byte descrambler.
`timescale 1ns / 1ps

package xpd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned METHOD_W = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned LANE_W   = 4;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [METHOD_W-1:0] t_method;
    typedef logic [LANE_W-1:0]   t_lane;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METHOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'b1;

    // Method codes with a meaning of their own
    localparam t_method METHOD_NONE = 2'd0;
    localparam t_method METHOD_ALT  = 2'd2;

    localparam t_byte CODE_PLAIN = 8'h6d;
    localparam t_byte CODE_ALT   = 8'had;
    localparam t_byte FLIP_BYTE  = 8'h0d;

    // Lanes whose output gets the extra flip
    localparam t_lane FLIP_LANE_LO = 4'd5;
    localparam t_lane FLIP_LANE_HI = 4'd6;

    localparam t_byte KEY_TABLE [16] = '{
        8'h4f, 8'hd0, 8'ha0, 8'hac, 8'h4a, 8'h5b, 8'hb9, 8'he5,
        8'h93, 8'h79, 8'h45, 8'ha5, 8'hc1, 8'hcb, 8'h31, 8'h93
    };

    // One input request as held in the input register
    typedef struct packed {
        t_byte data_in;
        logic  first;
    } t_item;

    // Input stage status handed to the core
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

endpackage

FILE: rtl/xpd_in_if.sv
// Input channel: scrambled byte plus buffer-start flag.
`timescale 1ns / 1ps

interface xpd_in_if;
    import xpd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_in;
    logic  first;

    modport source (output valid, output data_in, output first, input ready);
    modport sink   (input valid, input data_in, input first, output ready);
endinterface

FILE: rtl/xpd_out_if.sv
// Output channel: descrambled byte.
`timescale 1ns / 1ps

interface xpd_out_if;
    import xpd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

FILE: rtl/xpd_in_reg.sv
// Input register stage for the descrambler.
`timescale 1ns / 1ps

module xpd_in_reg
    import xpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_item  i_item,
    input  logic   i_take,     // core consumes the held request this cycle
    output t_stage o_stage
);

    logic  r_valid;
    t_item r_item;

    // Refill whenever the slot is empty or being drained
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

FILE: rtl/xpd_core.sv
// Descramble logic, running state, configuration and result register.
`timescale 1ns / 1ps

module xpd_core
    import xpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_byte                i_cfg_wdata,
    input  t_stage               i_stage,
    output logic                 o_take,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_byte                o_data
);

    t_method r_method;
    t_byte   r_seed;
    t_byte   r_pos;
    t_byte   r_prev;
    logic    r_out_valid;
    t_byte   r_out_data;

    t_byte        pos_eff;
    t_byte        prev_eff;
    t_byte        code;
    logic [15:0]  prod;
    t_lane        lane;
    t_byte        n_x;
    t_byte        n_y;
    logic         fire;

    assign o_take = !r_out_valid || i_ready;
    assign fire   = i_stage.valid && o_take;

    always_comb begin
        pos_eff  = i_stage.item.first ? '0 : r_pos;
        prev_eff = i_stage.item.first ? r_seed : r_prev;
        code     = (r_method == METHOD_ALT) ? CODE_ALT : CODE_PLAIN;
        prod     = pos_eff * code;
        lane     = pos_eff[LANE_W-1:0];
        n_x      = i_stage.item.data_in ^ KEY_TABLE[lane] ^ prod[BYTE_W-1:0];
        n_y      = n_x ^ prev_eff;
        if (r_method != METHOD_NONE && (lane == FLIP_LANE_LO || lane == FLIP_LANE_HI)) begin
            n_y = n_y ^ FLIP_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METHOD_NONE;
            r_seed   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_METHOD: r_method <= i_cfg_wdata[METHOD_W-1:0];
                REG_SEED:   r_seed   <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_pos       <= pos_eff + 8'd1;
            r_prev      <= n_x;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= n_y;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/xor_pack_descrambler.sv
// Top level of the pack-file byte descrambler.
`timescale 1ns / 1ps

// Descrambles a pack-file byte stream, one byte per request, one result per
// request. Each byte goes through an input register, then a short XOR path
// (key table lookup, an 8x8 product of the position with the method's code,
// XOR with the previous intermediate byte) into the result register. A new
// byte is taken every cycle while the output is not stalled: one byte per
// clock, set by the update of the position counter and previous-byte
// register. Setting first on a request restarts the position at 0 and seeds
// the previous byte from length_seed. Configuration (index 0: method, index
// 1: length_seed) is to be written by the user only while no request is in
// flight; the block itself does not enforce this.

module xor_pack_descrambler
    import xpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_byte                i_cfg_wdata,
    xpd_in_if.sink               i_in,
    xpd_out_if.source            o_out
);

    t_item  in_item;
    t_stage stage;
    logic   take;
    logic   in_ready;
    logic   out_valid;
    t_byte  out_data;

    assign in_item.data_in = i_in.data_in;
    assign in_item.first   = i_in.first;
    assign i_in.ready      = in_ready;

    // Input register: holds one request while the result register is stalled
    xpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_stage (stage)
    );

    // Descramble path, running state and result register
    xpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (stage),
        .o_take      (take),
        .o_valid     (out_valid),
        .i_ready     (o_out.ready),
        .o_data      (out_data)
    );

    assign o_out.valid    = out_valid;
    assign o_out.data_out = out_data;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the pack-file byte descrambler.
`timescale 1ns / 1ps

module testbench;
    import xpd_pkg::*;

    // Run limits and pacing
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;     // result passes the input and result registers after acceptance
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 180;
    localparam int HOLD_AT      = 400;   // accepted requests before the long stall
    localparam int HOLD_LEN     = 80;
    localparam int MAX_PRINTS   = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_byte                i_cfg_wdata;

    xpd_in_if  in_if ();
    xpd_out_if out_if ();

    xor_pack_descrambler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Requests waiting to be offered, and descrambled bytes awaiting the output
    t_item pending_reqs[$];
    t_byte expected_bytes[$];

    // Shadow of the block: configuration plus position / previous-x state
    t_method model_method;
    t_byte   model_seed;
    t_byte   model_pos;
    t_byte   model_prev;

    int send_idle_pct;
    int recv_stall_pct;
    int accepted_cnt;
    int error_count;
    int hold_left;
    bit hold_done;
    int cycle_cnt;
    t_byte want_byte;

    // Descramble one request and advance the shadow state.
    // first restarts the position and reloads previous-x from the seed.
    function automatic t_byte descramble(t_item req);
        t_byte code;
        t_byte x;
        t_byte y;
        t_lane lane;
        if (req.first) begin
            model_pos  = '0;
            model_prev = model_seed;
        end
        code = (model_method == METHOD_ALT) ? CODE_ALT : CODE_PLAIN;
        lane = model_pos[LANE_W-1:0];
        x = req.data_in ^ KEY_TABLE[lane] ^ t_byte'(model_pos * code);
        y = x ^ model_prev;
        // any nonzero method flips lanes 5 and 6
        if (model_method != METHOD_NONE && (lane == FLIP_LANE_LO || lane == FLIP_LANE_HI)) begin
            y = y ^ FLIP_BYTE;
        end
        model_prev = x;
        model_pos  = model_pos + 1'b1;
        return y;
    endfunction

    task automatic flag_error(string what, t_byte got, t_byte want);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR at %0t: %s: got %02h, expected %02h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Driver: offers pending requests, holds each one stable until accepted.
    // The expectation is computed at the edge where the request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.data_in <= '0;
            in_if.first   <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_bytes.push_back(descramble('{data_in: in_if.data_in,
                                                      first: in_if.first}));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid   <= 1'b1;
                    in_if.data_in <= pending_reqs[0].data_in;
                    in_if.first   <= pending_reqs[0].first;
                    void'(pending_reqs.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver stall: armed once after HOLD_AT accepted requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Monitor: checks each result against the oldest expectation and paces ready.
    // During the long stall the driver keeps offering and the block fills up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_bytes.size() == 0) begin
                    flag_error("result with nothing expected", out_if.data_out, 8'h00);
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (out_if.data_out !== want_byte) begin
                        flag_error("data_out mismatch", out_if.data_out, want_byte);
                    end
                end
            end
            if (hold_left > 0 || (!hold_done && accepted_cnt >= HOLD_AT)) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Register write; the shadow copy follows right away since nothing is in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_byte val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == REG_METHOD) begin
            model_method = t_method'(val);
        end else begin
            model_seed = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(t_method m, t_byte seed);
        write_reg(REG_METHOD, t_byte'(m));
        write_reg(REG_SEED, seed);
    endtask

    // Wait until every request has been taken and every result checked;
    // sampled on the falling edge so the driver's updates have settled
    task automatic drain();
        while (pending_reqs.size() > 0 || in_if.valid || expected_bytes.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_req(t_byte b, logic f);
        pending_reqs.push_back('{data_in: b, first: f});
    endtask

    // Random buffers: mostly short, a few long ones cut to the items left.
    // Now and then a buffer carries no first flag and just continues the last one.
    task automatic queue_buffers(int n_items);
        int left;
        int len;
        int k;
        t_byte b;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 40);
            if (len > left) len = left;
            for (k = 0; k < len; k++) begin
                case ($urandom_range(7))
                    0: b = 8'h00;
                    1: b = 8'hff;
                    default: b = t_byte'($urandom);
                endcase
                add_req(b, (k == 0) && ($urandom_range(15) != 0));
            end
            left -= len;
        end
    endtask

    initial begin
        int seg;
        int k;
        t_method m;
        t_byte seed;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_METHOD;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.data_in  = '0;
        in_if.first    = 1'b0;
        out_if.ready   = 1'b0;
        model_method   = METHOD_NONE;
        model_seed     = '0;
        model_pos      = '0;
        model_prev     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        accepted_cnt   = 0;
        error_count    = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        cycle_cnt      = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no first flag after reset runs from position 0, previous 0
        add_req(8'h00, 1'b0);
        add_req(8'hff, 1'b0);
        add_req(8'ha5, 1'b0);
        drain();

        // Method 1 with full seed: plain code, flips on lanes 5 and 6
        set_config(t_method'(1), 8'hff);
        add_req(8'hff, 1'b1);
        for (k = 1; k < 8; k++) add_req(t_byte'(8'h01 << (k - 1)), 1'b0);
        drain();

        // Alternate code, zero seed
        set_config(METHOD_ALT, 8'h00);
        add_req(8'h00, 1'b1);
        for (k = 1; k < 8; k++) add_req(t_byte'(8'h80 >> (k - 1)), 1'b0);
        drain();

        // Method 3: plain code with flips; back-to-back buffer starts
        set_config(t_method'(3), 8'h5a);
        add_req(8'h3c, 1'b1);
        add_req(8'hc3, 1'b1);
        add_req(8'hff, 1'b0);
        add_req(8'h00, 1'b1);
        drain();

        // Random segments, each with its own setting; pacing moves from a slow
        // receiver to a slow sender and finally to full rate
        for (seg = 0; seg < SEGMENTS; seg++) begin
            m = t_method'(seg % 4);
            case (seg)
                0: seed = 8'h00;
                1: seed = 8'hff;
                default: seed = t_byte'($urandom);
            endcase
            set_config(m, seed);
            if (seg < 3) begin
                send_idle_pct  = 6;
                recv_stall_pct = 69;
            end else if (seg < 6) begin
                send_idle_pct  = 69;
                recv_stall_pct = 6;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            queue_buffers(SEG_ITEMS);
            drain();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/xpd_pkg.sv
rtl/xpd_in_if.sv
rtl/xpd_out_if.sv
rtl/xpd_in_reg.sv
rtl/xpd_core.sv
rtl/xor_pack_descrambler.sv
tb/testbench.sv
